// ===== hw/rtl/sil_pkg.sv =====
// Package for the sorted insert list: command codes, cell operation codes
// and fixed field widths of the input and result channels. No dependencies.
`default_nettype none

package sil_pkg;

  localparam int OUT_VALUE_W = 32;
  localparam int IN_VALUE_W  = 32;
  localparam int POS_W       = 5;
  localparam int CNT_W       = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t OP_HOLD   = 2'd0;
  localparam cell_op_t OP_INSERT = 2'd1;
  localparam cell_op_t OP_ROTATE = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/sil_cell.sv =====
// One storage cell of the sorted chain: holds a value, compares it with the
// incoming value, and shifts or rotates with its neighbors. Uses sil_pkg.
`default_nettype none

module sil_cell #(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = 32,
  parameter int CW         = 6
) (
  input  wire                          clk,
  input  wire sil_pkg::cell_op_t       op,
  input  wire [CW-1:0]                 count,
  input  wire signed [VALUE_BITS-1:0]  new_val,
  input  wire signed [VALUE_BITS-1:0]  left_val,
  input  wire                          left_flag,
  input  wire signed [VALUE_BITS-1:0]  right_val,
  input  wire signed [VALUE_BITS-1:0]  head_val,
  output logic signed [VALUE_BITS-1:0] val,
  output logic                         flag
);
  import sil_pkg::*;

  logic signed [VALUE_BITS-1:0] val_r;
  logic signed [VALUE_BITS-1:0] val_nxt;
  logic                         occ;
  logic                         tail;

  assign occ  = CW'(IDX) < count;
  assign tail = occ && (CW'(IDX) + CW'(1) == count);
  // set when this cell is empty or holds a value not below the new one
  assign flag = !occ || (val_r >= new_val);
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    unique case (op)
      OP_INSERT: begin
        if (flag && left_flag) begin
          val_nxt = left_val;
        end else if (flag) begin
          val_nxt = new_val;
        end
      end
      OP_ROTATE: begin
        if (tail) begin
          val_nxt = head_val;
        end else if (occ) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_insert_list.sv =====
// Top level of the sorted insert list: a chain of sil_cell instances kept in
// ascending order, a fill count, the dump sequencer and the result register.
// Depends on sil_pkg and sil_cell.
//
//   channel  ports                          transfer
//   input    start busy in_cmd in_item_*     start && !busy at rising edge
//   result   out_valid out_*                 out_valid high, one cycle each
//
// On an insert all cells compare against the new value at once and the chain
// shifts in the same cycle; its result shows in the next cycle.
// A dump sends the entries in ascending order, rotating the chain one cell a
// cycle through cell 0; busy stays high until the last entry is sent. An empty
// dump or a full-store insert gives a single result. Reset clears the fill count,
// busy and the strobe; cell contents stay undefined until written. The
// receiver cannot stall, so results never wait.
`default_nettype none

module sorted_insert_list #(
  parameter int DEPTH      = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire                                in_cmd,
  input  wire signed [sil_pkg::IN_VALUE_W-1:0] in_item_value,
  output logic                               out_valid,
  output logic signed [sil_pkg::OUT_VALUE_W-1:0] out_value,
  output logic [sil_pkg::POS_W-1:0]          out_position,
  output logic                               out_last,
  output logic [sil_pkg::CNT_W-1:0]          out_entry_count,
  output logic                               out_dropped,
  output logic                               out_empty_res
);
  import sil_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VALUE_BITS-1:0] new_val;
  logic signed [VALUE_BITS-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]             flags;
  logic [DEPTH-1:0]             take_new;
  logic [IW-1:0]                ins_pos;
  cell_op_t                     op;

  logic          accept;
  logic          full;
  logic          dump_last;
  logic          busy_r, busy_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [OUT_VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [POS_W-1:0]              out_position_r, out_position_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [CNT_W-1:0]              out_count_r, out_count_nxt;
  logic                          out_dropped_r, out_dropped_nxt;
  logic                          out_empty_r, out_empty_nxt;

  assign new_val   = VALUE_BITS'(in_item_value);
  assign accept    = start && !busy_r;
  assign full      = count_r == CW'(DEPTH);
  assign dump_last = CW'(idx_r) + CW'(1) == count_r;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_BITS-1:0] left_v;
      logic signed [VALUE_BITS-1:0] right_v;
      logic                         left_f;
      if (g == 0) begin : g_head
        assign left_v = new_val;
        assign left_f = 1'b0;
      end else begin : g_body
        assign left_v = cell_val[g-1];
        assign left_f = flags[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
        assign right_v = cell_val[0];
      end else begin : g_mid
        assign right_v = cell_val[g+1];
      end
      sil_cell #(
        .IDX        (g),
        .VALUE_BITS (VALUE_BITS),
        .CW         (CW)
      ) u_cell (
        .clk       (clk),
        .op        (op),
        .count     (count_r),
        .new_val   (new_val),
        .left_val  (left_v),
        .left_flag (left_f),
        .right_val (right_v),
        .head_val  (cell_val[0]),
        .val       (cell_val[g]),
        .flag      (flags[g])
      );
      assign take_new[g] = flags[g] && !left_f;
    end
  endgenerate

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (take_new[i]) begin
        ins_pos = ins_pos | IW'(i);
      end
    end
  end

  always_comb begin
    op               = OP_HOLD;
    busy_nxt         = busy_r;
    idx_nxt          = idx_r;
    count_nxt        = count_r;
    out_valid_nxt    = 1'b0;
    out_value_nxt    = '0;
    out_position_nxt = '0;
    out_last_nxt     = 1'b1;
    out_count_nxt    = CNT_W'(count_r);
    out_dropped_nxt  = 1'b0;
    out_empty_nxt    = 1'b0;
    priority if (busy_r) begin
      op               = OP_ROTATE;
      out_valid_nxt    = 1'b1;
      out_value_nxt    = OUT_VALUE_W'(cell_val[0]);
      out_position_nxt = POS_W'(idx_r);
      out_last_nxt     = dump_last;
      idx_nxt          = idx_r + IW'(1);
      if (dump_last) begin
        busy_nxt = 1'b0;
      end
    end else if (accept && in_cmd == CMD_INSERT) begin
      out_valid_nxt = 1'b1;
      if (full) begin
        out_dropped_nxt = 1'b1;
      end else begin
        op               = OP_INSERT;
        count_nxt        = count_r + CW'(1);
        out_count_nxt    = CNT_W'(count_r + CW'(1));
        out_position_nxt = POS_W'(ins_pos);
      end
    end else if (accept) begin
      if (count_r == '0) begin
        out_valid_nxt = 1'b1;
        out_empty_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        idx_nxt  = '0;
      end
    end else begin
      op = OP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    out_value_r    <= out_value_nxt;
    out_position_r <= out_position_nxt;
    out_last_r     <= out_last_nxt;
    out_count_r    <= out_count_nxt;
    out_dropped_r  <= out_dropped_nxt;
    out_empty_r    <= out_empty_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_position    = out_position_r;
  assign out_last        = out_last_r;
  assign out_entry_count = out_count_r;
  assign out_dropped     = out_dropped_r;
  assign out_empty_res   = out_empty_r;

endmodule

`default_nettype wire

// ===== sim/sorted_insert_list_tb.sv =====
// Self-checking testbench for sorted_insert_list: directed table and random inserts and dumps.
// The expected result queue is filled by an in-bench sorted-list predictor.
// Depends on sil_pkg and the sorted_insert_list RTL.
module sorted_insert_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sil_pkg::*;

  localparam int DEPTH        = 32;
  localparam int RANDOM_ITEMS = 100;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic signed [OUT_VALUE_W-1:0] value;
    logic [POS_W-1:0]              position;
    logic                          last;
    logic [CNT_W-1:0]              count;
    logic                          dropped;
    logic                          empty;
  } list_result_t;

  typedef struct {
    logic                         cmd;
    logic signed [IN_VALUE_W-1:0] value;
    bit                           typed;
    list_result_t                 result;
  } list_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_cmd;
  logic signed [IN_VALUE_W-1:0]  in_item_value;
  logic                          out_valid;
  logic signed [OUT_VALUE_W-1:0] out_value;
  logic [POS_W-1:0]              out_position;
  logic                          out_last;
  logic [CNT_W-1:0]              out_entry_count;
  logic                          out_dropped;
  logic                          out_empty_res;

  logic signed [IN_VALUE_W-1:0] ordered_vals[$];
  list_result_t                 expected_results[$];
  list_row_t                    directed_rows[$];
  int                           mismatches = 0;
  int                           quiet_cycles = 0;

  sorted_insert_list #(
    .DEPTH     (DEPTH),
    .VALUE_BITS(32)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_position   (out_position),
    .out_last       (out_last),
    .out_entry_count(out_entry_count),
    .out_dropped    (out_dropped),
    .out_empty_res  (out_empty_res)
  );

  always #5 clk = ~clk;

  function automatic list_result_t make_result(input logic signed [31:0] value, input int pos,
                                               input bit last, input int count,
                                               input bit dropped, input bit empty);
    list_result_t r;
    r.value    = value;
    r.position = POS_W'(pos);
    r.last     = last;
    r.count    = CNT_W'(count);
    r.dropped  = dropped;
    r.empty    = empty;
    return r;
  endfunction

  task automatic sort_and_report(input logic cmd, input logic signed [IN_VALUE_W-1:0] value);
    int slot;
    int fill;
    fill = ordered_vals.size();
    if (cmd == CMD_INSERT) begin
      if (fill >= DEPTH) begin
        expected_results.push_back(make_result(0, 0, 1'b1, fill, 1'b1, 1'b0));
      end else begin
        slot = 0;
        while (slot < fill && ordered_vals[slot] < value) slot++;
        ordered_vals.insert(slot, value);
        expected_results.push_back(make_result(0, slot, 1'b1, fill + 1, 1'b0, 1'b0));
      end
    end else if (fill == 0) begin
      expected_results.push_back(make_result(0, 0, 1'b1, 0, 1'b0, 1'b1));
    end else begin
      for (int i = 0; i < fill; i++)
        expected_results.push_back(make_result(ordered_vals[i], i, i == fill - 1, fill,
                                               1'b0, 1'b0));
    end
  endtask

  task automatic add_row(input logic cmd, input logic signed [IN_VALUE_W-1:0] value,
                         input bit typed, input list_result_t result);
    list_row_t row;
    row.cmd    = cmd;
    row.value  = value;
    row.typed  = typed;
    row.result = result;
    directed_rows.push_back(row);
  endtask

  task automatic transfer_item(input list_row_t row, input bit idle_ok);
    @(negedge clk);
    while (idle_ok && $urandom_range(0, 99) < 15) begin
      start = 1'b0;
      @(negedge clk);
    end
    start         = 1'b1;
    in_cmd        = row.cmd;
    in_item_value = row.value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sort_and_report(row.cmd, row.value);
    if (row.typed) expected_results[$] = row.result;
  endtask

  function automatic logic signed [IN_VALUE_W-1:0] pick_value();
    logic signed [IN_VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2, 3, 4: v = $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default: v = $signed($urandom);
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %0d position %0d", out_value, out_position);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_value !== exp_r.value) begin
          $error("out_value: expected %0d, got %0d", exp_r.value, out_value);
          mismatches++;
        end
        if (out_position !== exp_r.position) begin
          $error("out_position: expected %0d, got %0d", exp_r.position, out_position);
          mismatches++;
        end
        if (out_last !== exp_r.last) begin
          $error("out_last: expected %0b, got %0b", exp_r.last, out_last);
          mismatches++;
        end
        if (out_entry_count !== exp_r.count) begin
          $error("out_entry_count: expected %0d, got %0d", exp_r.count, out_entry_count);
          mismatches++;
        end
        if (out_dropped !== exp_r.dropped) begin
          $error("out_dropped: expected %0b, got %0b", exp_r.dropped, out_dropped);
          mismatches++;
        end
        if (out_empty_res !== exp_r.empty) begin
          $error("out_empty_res: expected %0b, got %0b", exp_r.empty, out_empty_res);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    list_result_t none;
    list_row_t    row;
    none          = make_result(0, 0, 1'b0, 0, 1'b0, 1'b0);
    rst_n         = 1'b0;
    start         = 1'b0;
    in_cmd        = CMD_INSERT;
    in_item_value = '0;

    add_row(CMD_DUMP,   0,            1'b1, make_result(0, 0, 1'b1, 0, 1'b0, 1'b1));
    add_row(CMD_INSERT, 0,            1'b1, make_result(0, 0, 1'b1, 1, 1'b0, 1'b0));
    add_row(CMD_INSERT, 32'sh7FFF_FFFF, 1'b1, make_result(0, 1, 1'b1, 2, 1'b0, 1'b0));
    add_row(CMD_INSERT, 32'sh8000_0000, 1'b1, make_result(0, 0, 1'b1, 3, 1'b0, 1'b0));
    // equal value goes ahead of the older one
    add_row(CMD_INSERT, 0,            1'b1, make_result(0, 1, 1'b1, 4, 1'b0, 1'b0));
    add_row(CMD_INSERT, -1,           1'b1, make_result(0, 1, 1'b1, 5, 1'b0, 1'b0));
    add_row(CMD_DUMP,   32'sh1234_5678, 1'b0, none);
    add_row(CMD_INSERT, 32'sh5555_5555, 1'b0, none);
    add_row(CMD_INSERT, 32'shAAAA_AAAA, 1'b0, none);
    add_row(CMD_INSERT, 32'sh7FFF_FFFF, 1'b0, none);
    add_row(CMD_INSERT, 32'sh8000_0000, 1'b0, none);
    add_row(CMD_INSERT, 1,            1'b0, none);
    add_row(CMD_DUMP,   -1,           1'b0, none);
    add_row(CMD_DUMP,   0,            1'b0, none);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) transfer_item(directed_rows[i], 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      row.cmd    = ($urandom_range(0, 99) < 15) ? CMD_DUMP : CMD_INSERT;
      row.value  = pick_value();
      row.typed  = 1'b0;
      row.result = none;
      transfer_item(row, !(n >= 30 && n < 60));
    end

    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sil_pkg.sv
hw/rtl/sil_cell.sv
hw/rtl/sorted_insert_list.sv
sim/sorted_insert_list_tb.sv
